// File: rtl/core/wprm_pkg.sv
// ----------------------------------------------------------------------------
// wprm_pkg: shared types and constants
// Byte codes, command codes and sequencer states for the path rule matcher.
// ----------------------------------------------------------------------------
package wprm_pkg;

  localparam logic [7:0] StarByte   = 8'h2A;
  localparam logic [7:0] AnchorByte = 8'h24;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_RULE  = 2'd1,
    CMD_PATH  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RULE_START,
    ST_LEN_WAIT,
    ST_ANCHOR_RD,
    ST_ANCHOR_WAIT,
    ST_STEP_RD,
    ST_STEP_WAIT,
    ST_STEP,
    ST_TAIL_RD,
    ST_TAIL_WAIT,
    ST_TAIL,
    ST_RULE_DONE,
    ST_RESULT
  } state_e;

endpackage

// File: rtl/core/wprm_pattern_mem.sv
// ----------------------------------------------------------------------------
// wprm_pattern_mem: pattern byte store
// One write port and one registered read port over all rule patterns.
// ----------------------------------------------------------------------------
module wprm_pattern_mem #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/wildcard_path_rule_matcher_top.sv
// ----------------------------------------------------------------------------
// wildcard_path_rule_matcher_top: allow/disallow rule matcher for URL paths
// ----------------------------------------------------------------------------
// Input beats on s_axis carry a command: clear the rule table, a pattern byte
// or a path byte. Pattern and path bytes are taken one per cycle. The path
// beat with tlast set starts an evaluation: a sequencer walks every stored
// rule, comparing pattern bytes against the buffered path with one shared byte
// comparator, backtracking on '*'. Each compare step is a pattern memory
// read, its registered data and the compare. With an empty table or an
// overlong path the sequencer goes from idle straight to its result step,
// which registers the verdict beat. s_axis_tready is low while an
// evaluation runs. One result beat appears on m_axis; it is held until
// m_axis_tready takes it. Input beats are still taken while a verdict waits,
// but a further evaluation holds in its result step until the waiting
// verdict has left. Reset empties the rule table, the path buffer and the
// overflow flag and sets the table_valid register to one. The memories are
// not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module wildcard_path_rule_matcher_top
  import wprm_pkg::*;
#(
  parameter int unsigned MAX_RULES = 32,
  parameter int unsigned PATH_MAX  = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: [1:0] cmd, [9:2] data_byte, [15:10] zero
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  // tuser: [0] rule_is_allow
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: [0] allowed, [1] rule_found, [6:2] rule_index, [7] rule_allows,
  //        [14:8] rule_length, [15] path_too_long, [16] table_overflow,
  //        [23:17] zero
  output logic [23:0] m_axis_tdata
);

  localparam int unsigned RW   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CW   = $clog2(MAX_RULES + 1);
  localparam int unsigned PW   = (PATH_MAX > 1) ? $clog2(PATH_MAX) : 1;
  localparam int unsigned LW   = $clog2(PATH_MAX + 1);
  localparam int unsigned AW   = RW + PW;

  // Unpacked input fields.
  logic [1:0] in_cmd;
  logic [7:0] in_byte;
  assign in_cmd  = s_axis_tdata[1:0];
  assign in_byte = s_axis_tdata[9:2];

  logic beat;
  assign beat = s_axis_tvalid && s_axis_tready;

  // Control state.
  state_e     state_q, state_d;
  logic       tv_q;
  logic [CW-1:0] total_q;
  logic [LW-1:0] cursor_q;
  logic       discard_q, over_q, ovf_q;
  logic [LW-1:0] plen_q;

  // Rule evaluation registers.
  logic [RW-1:0] r_q, r_d;
  logic [LW-1:0] len_q, len_d;      // pattern length without anchor
  logic [LW-1:0] full_q, full_d;    // stored length
  logic       kind_q, kind_d, anch_q, anch_d;
  logic [LW-1:0] pi_q, pi_d, si_q, si_d, star_q, star_d, res_q, res_d;
  logic       hs_q, hs_d, hit_q, hit_d;
  logic       fnd_q, fnd_d, bkind_q, bkind_d;
  logic [RW-1:0] best_q, best_d;
  logic [LW-1:0] blen_q, blen_d;
  logic [23:0] out_q, out_d;
  logic       ovld_q, ovld_d;

  // Small tables held in flip-flops, and the path buffer.
  logic [LW-1:0] lens_q  [MAX_RULES];
  logic          kinds_q [MAX_RULES];
  logic [7:0]    path_q  [PATH_MAX];
  logic [7:0]    path_byte_q;

  // Pattern memory.
  logic          pm_we;
  logic [AW-1:0] pm_waddr, pm_raddr;
  logic [7:0]    pm_rdata;
  logic [LW-1:0] rd_idx;

  assign pm_we    = beat && in_cmd == CMD_RULE && total_q < CW'(MAX_RULES)
                    && cursor_q < LW'(PATH_MAX - 1);
  assign pm_waddr = {total_q[RW-1:0], cursor_q[PW-1:0]};
  assign pm_raddr = {r_q, rd_idx[PW-1:0]};

  wprm_pattern_mem #(.Depth(MAX_RULES * (2 ** PW)), .AddrW(AW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (pm_we),
    .waddr_i(pm_waddr),
    .wdata_i(in_byte),
    .raddr_i(pm_raddr),
    .rdata_o(pm_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = out_q;

  // The result step completes once the output register is free.
  logic res_go;
  assign res_go = (state_q == ST_RESULT) && (!ovld_q || m_axis_tready);

  // Loading side: rule bookkeeping, path buffer and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q      <= 1'b1;
      total_q   <= '0;
      cursor_q  <= '0;
      discard_q <= 1'b0;
      ovf_q     <= 1'b0;
      plen_q    <= '0;
      over_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tv_q <= cfg_wdata_i;
      end
      if (beat && in_cmd == CMD_CLEAR) begin
        total_q   <= '0;
        cursor_q  <= '0;
        discard_q <= 1'b0;
        ovf_q     <= 1'b0;
      end else if (beat && in_cmd == CMD_RULE) begin
        if (s_axis_tlast) begin
          if (total_q >= CW'(MAX_RULES) || discard_q || !pm_we) begin
            ovf_q <= 1'b1;
          end else begin
            total_q <= total_q + 1'b1;
          end
          cursor_q  <= '0;
          discard_q <= 1'b0;
        end else if (pm_we) begin
          cursor_q <= cursor_q + 1'b1;
        end else begin
          discard_q <= 1'b1;
        end
      end else if (beat && in_cmd == CMD_PATH) begin
        if (plen_q < LW'(PATH_MAX)) begin
          plen_q <= plen_q + 1'b1;
        end else begin
          over_q <= 1'b1;
        end
      end else if (res_go) begin
        plen_q <= '0;
        over_q <= 1'b0;
      end
    end
  end

  // Payload tables and the registered path byte read.
  always_ff @(posedge clk_i) begin
    if (beat && in_cmd == CMD_RULE && s_axis_tlast && pm_we && !discard_q) begin
      lens_q[total_q[RW-1:0]]  <= cursor_q + 1'b1;
      kinds_q[total_q[RW-1:0]] <= s_axis_tuser;
    end
    if (beat && in_cmd == CMD_PATH && plen_q < LW'(PATH_MAX)) begin
      path_q[plen_q[PW-1:0]] <= in_byte;
    end
    path_byte_q <= path_q[si_q[PW-1:0]];
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;       len_q <= len_d;   full_q <= full_d;
    kind_q <= kind_d; anch_q <= anch_d;
    pi_q <= pi_d;     si_q <= si_d;     star_q <= star_d;  res_q <= res_d;
    hs_q <= hs_d;     hit_q <= hit_d;
    fnd_q <= fnd_d;   bkind_q <= bkind_d; best_q <= best_d; blen_q <= blen_d;
    out_q <= out_d;
  end

  // Shared byte compare against the current path byte.
  logic       is_star, eq;
  assign is_star   = pm_rdata == StarByte;
  assign eq        = pm_rdata == path_byte_q;

  logic last_rule;
  assign last_rule = (CW'(r_q) + CW'(1)) >= total_q;

  // Next state and evaluation datapath.
  always_comb begin
    state_d = state_q; ovld_d = ovld_q;
    r_d = r_q; len_d = len_q; full_d = full_q; kind_d = kind_q; anch_d = anch_q;
    pi_d = pi_q; si_d = si_q; star_d = star_q; res_d = res_q;
    hs_d = hs_q; hit_d = hit_q;
    fnd_d = fnd_q; bkind_d = bkind_q; best_d = best_q; blen_d = blen_q;
    out_d = out_q;
    rd_idx = pi_q;
    if (ovld_q && m_axis_tready) begin
      ovld_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (beat && in_cmd == CMD_PATH && s_axis_tlast) begin
          r_d = '0; fnd_d = 1'b0; bkind_d = 1'b0; best_d = '0; blen_d = '0;
          if (over_q || plen_q >= LW'(PATH_MAX) || total_q == '0) begin
            state_d = ST_RESULT;
          end else begin
            state_d = ST_RULE_START;
          end
        end
      end
      ST_RULE_START: begin
        full_d = lens_q[r_q];
        kind_d = kinds_q[r_q];
        state_d = ST_LEN_WAIT;
      end
      ST_LEN_WAIT: begin
        pi_d = '0; si_d = '0; hs_d = 1'b0; hit_d = 1'b0; anch_d = 1'b0;
        len_d = full_q;
        if (full_q == '0) begin
          state_d = ST_STEP_RD;
        end else begin
          state_d = ST_ANCHOR_RD;
        end
      end
      ST_ANCHOR_RD: begin
        rd_idx = full_q - 1'b1;
        state_d = ST_ANCHOR_WAIT;
      end
      ST_ANCHOR_WAIT: begin
        // The last stored byte is on the read port now.
        if (pm_rdata == AnchorByte) begin
          anch_d = 1'b1;
          len_d  = full_q - 1'b1;
        end
        state_d = ST_STEP_RD;
      end
      ST_STEP_RD: begin
        if (si_q >= plen_q) begin
          state_d = ST_TAIL_RD;
        end else begin
          state_d = ST_STEP_WAIT;
        end
      end
      ST_STEP_WAIT: begin
        state_d = ST_STEP;
      end
      ST_STEP: begin
        state_d = ST_STEP_RD;
        if (pi_q < len_q && is_star) begin
          star_d = pi_q; hs_d = 1'b1; pi_d = pi_q + 1'b1; res_d = si_q;
        end else if (pi_q < len_q && eq) begin
          pi_d = pi_q + 1'b1; si_d = si_q + 1'b1;
        end else if (hs_q) begin
          pi_d = star_q + 1'b1; res_d = res_q + 1'b1; si_d = res_q + 1'b1;
        end else begin
          hit_d = 1'b0; state_d = ST_RULE_DONE;
        end
        if (state_d == ST_STEP_RD && pi_d == len_q && !anch_q) begin
          hit_d = 1'b1; state_d = ST_RULE_DONE;
        end
      end
      ST_TAIL_RD: begin
        if (pi_q >= len_q) begin
          hit_d = 1'b1; state_d = ST_RULE_DONE;
        end else begin
          state_d = ST_TAIL_WAIT;
        end
      end
      ST_TAIL_WAIT: begin
        state_d = ST_TAIL;
      end
      ST_TAIL: begin
        if (is_star) begin
          pi_d = pi_q + 1'b1; state_d = ST_TAIL_RD;
        end else begin
          hit_d = 1'b0; state_d = ST_RULE_DONE;
        end
      end
      ST_RULE_DONE: begin
        if (hit_q && (!fnd_q || full_q > blen_q || (full_q == blen_q && kind_q))) begin
          fnd_d = 1'b1; best_d = r_q; blen_d = full_q; bkind_d = kind_q;
        end
        if (last_rule) begin
          state_d = ST_RESULT;
        end else begin
          r_d = r_q + 1'b1; state_d = ST_RULE_START;
        end
      end
      ST_RESULT: begin
        if (res_go) begin
          out_d = '0;
          out_d[0]    = tv_q && !ovf_q && !over_q && (!fnd_q || bkind_q);
          out_d[1]    = fnd_q;
          out_d[6:2]  = fnd_q ? 5'(best_q) : 5'd0;
          out_d[7]    = fnd_q && bkind_q;
          out_d[14:8] = fnd_q ? 7'(blen_q) : 7'd0;
          out_d[15]   = over_q;
          out_d[16]   = ovf_q;
          ovld_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
